>>> rtl/plgn_pkg.sv
// shared constants, codes and types for the perlin gradient noise block
package plgn_pkg;

   localparam int TableSize  = 256;
   localparam int IdxBits    = $clog2(TableSize);
   localparam int FracBits   = 16;
   localparam int MaxOctaves = 8;
   localparam int OctBits    = $clog2(MaxOctaves);
   localparam int CntBits    = 4;
   localparam int GradBits   = 16;
   localparam int OutBits    = 21;

   // widths along the corner datapath
   localparam int SmBits   = FracBits + 1;             // smoothstep and weights
   localparam int OffBits  = FracBits + 2;             // signed corner offset
   localparam int DotBits  = GradBits + OffBits + 2;   // sum of three products
   localparam int DshBits  = DotBits - 14;             // dot after the Q1.14 shift
   localparam int ProdBits = SmBits + 1 + DshBits;     // weight times dot
   localparam int AccBits  = ProdBits + 3;             // eight corners
   localparam int NoiseBits = AccBits - FracBits;
   localparam int TotBits  = NoiseBits + MaxOctaves - 1 + OctBits;

   typedef enum logic [1:0] {
      OP_LOAD_GRAD = 2'd0,
      OP_LOAD_PERM = 2'd1,
      OP_EVAL      = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic REG_MODE    = 1'b0;
   localparam logic REG_OCTAVES = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic                 oct_last;
      logic                 item_last;
      logic [OctBits-1:0]   octave;
      logic                 hi_x;
      logic                 hi_y;
      logic                 hi_z;
   } tag_type;

   typedef struct packed {
      logic                  grad_we;
      logic [2:0]            perm_we;
      logic [IdxBits-1:0]    index;
      logic [IdxBits-1:0]    perm_value;
      logic [3*GradBits-1:0] grad;
   } tbl_wr_type;

endpackage

>>> rtl/plgn_tables.sv
// permutation and gradient table memories with registered reads
module plgn_tables (
   input  logic                                   clock,
   input  plgn_pkg::tbl_wr_type                   wr,
   input  logic [plgn_pkg::IdxBits-1:0]           perm_addr_x,
   input  logic [plgn_pkg::IdxBits-1:0]           perm_addr_y,
   input  logic [plgn_pkg::IdxBits-1:0]           perm_addr_z,
   output logic [plgn_pkg::IdxBits-1:0]           perm_x,
   output logic [plgn_pkg::IdxBits-1:0]           perm_y,
   output logic [plgn_pkg::IdxBits-1:0]           perm_z,
   input  logic [plgn_pkg::IdxBits-1:0]           grad_addr,
   output logic [3*plgn_pkg::GradBits-1:0]        grad_data
);

   logic [plgn_pkg::IdxBits-1:0]    perm_x_mem [plgn_pkg::TableSize];
   logic [plgn_pkg::IdxBits-1:0]    perm_y_mem [plgn_pkg::TableSize];
   logic [plgn_pkg::IdxBits-1:0]    perm_z_mem [plgn_pkg::TableSize];
   logic [3*plgn_pkg::GradBits-1:0] grad_mem   [plgn_pkg::TableSize];

   always_ff @(posedge clock) begin
      if (wr.perm_we[0]) begin
         perm_x_mem[wr.index] <= wr.perm_value;
      end
      perm_x <= perm_x_mem[perm_addr_x];
   end

   always_ff @(posedge clock) begin
      if (wr.perm_we[1]) begin
         perm_y_mem[wr.index] <= wr.perm_value;
      end
      perm_y <= perm_y_mem[perm_addr_y];
   end

   always_ff @(posedge clock) begin
      if (wr.perm_we[2]) begin
         perm_z_mem[wr.index] <= wr.perm_value;
      end
      perm_z <= perm_z_mem[perm_addr_z];
   end

   always_ff @(posedge clock) begin
      if (wr.grad_we) begin
         grad_mem[wr.index] <= wr.grad;
      end
      grad_data <= grad_mem[grad_addr];
   end

endmodule

>>> rtl/plgn_corner_pipe.sv
// five stage corner datapath: smoothstep weights, gradient dot, weighted product
module plgn_corner_pipe (
   input  logic                                  clock,
   input  logic                                  reset,
   input  plgn_pkg::tag_type                     tag_in,
   input  logic [plgn_pkg::FracBits-1:0]         frac_x,
   input  logic [plgn_pkg::FracBits-1:0]         frac_y,
   input  logic [plgn_pkg::FracBits-1:0]         frac_z,
   input  logic [plgn_pkg::IdxBits-1:0]          perm_x,
   input  logic [plgn_pkg::IdxBits-1:0]          perm_y,
   input  logic [plgn_pkg::IdxBits-1:0]          perm_z,
   output logic [plgn_pkg::IdxBits-1:0]          grad_addr,
   input  logic [3*plgn_pkg::GradBits-1:0]       grad_data,
   output plgn_pkg::tag_type                     tag_out,
   output logic signed [plgn_pkg::ProdBits-1:0]  prod_out
);

   localparam int F   = plgn_pkg::FracBits;
   localparam int SB  = plgn_pkg::SmBits;
   localparam int OB  = plgn_pkg::OffBits;
   localparam int GB  = plgn_pkg::GradBits;
   localparam int PB  = 2 * F;                 // square of a fraction
   localparam int MB  = F + OB;                // smoothstep product
   localparam int WB  = 2 * SB;                // weight product
   localparam int DPB = GB + OB;               // one dot term
   localparam logic [OB-1:0] Three = OB'(3 * (1 << F));
   localparam logic [SB-1:0] One   = SB'(1 << F);
   localparam logic [OB-1:0] OneO  = OB'(1 << F);

   // stage 1
   plgn_pkg::tag_type t1_ff;
   logic [F-1:0]   fr1_ff [3];
   logic [PB-1:0]  sq1_ff [3];
   // stage 2
   plgn_pkg::tag_type t2_ff;
   logic [F-1:0]   fr2_ff [3];
   logic [MB-1:0]  smp2_ff [3];
   // stage 3
   plgn_pkg::tag_type t3_ff;
   logic [WB-1:0]  wxy3_ff;
   logic [SB-1:0]  wz3_ff;
   logic signed [DPB-1:0] dp3_ff [3];
   // stage 4
   plgn_pkg::tag_type t4_ff;
   logic [SB-1:0]  w4_ff;
   logic signed [plgn_pkg::DshBits-1:0] dsh4_ff;
   // stage 5
   plgn_pkg::tag_type t5_ff;
   logic signed [plgn_pkg::ProdBits-1:0] prod5_ff;

   logic [F-1:0]   fr_in [3];
   logic [SB-1:0]  sm [3];
   logic [SB-1:0]  wt [3];
   logic           hi [3];
   logic signed [GB-1:0] g [3];
   logic signed [OB-1:0] off [3];
   logic signed [plgn_pkg::DotBits-1:0] dsum;
   logic [WB+SB-1:0] wprod;

   always_comb begin
      fr_in[0] = frac_x;
      fr_in[1] = frac_y;
      fr_in[2] = frac_z;
      hi[0] = t2_ff.hi_x;
      hi[1] = t2_ff.hi_y;
      hi[2] = t2_ff.hi_z;
      for (int a = 0; a < 3; a++) begin
         sm[a]  = smp2_ff[a][F+SB-1:F];
         wt[a]  = hi[a] ? sm[a] : One - sm[a];
         g[a]   = grad_data[a*GB +: GB];
         off[a] = $signed({2'b00, fr2_ff[a]} - (hi[a] ? OneO : '0));
      end
      dsum = plgn_pkg::DotBits'(dp3_ff[0]) + plgn_pkg::DotBits'(dp3_ff[1])
           + plgn_pkg::DotBits'(dp3_ff[2]);
      wprod = {1'b0, wxy3_ff[WB-1:F]} * wz3_ff;
   end

   assign grad_addr = perm_x ^ perm_y ^ perm_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
         t5_ff <= '0;
      end else begin
         t1_ff <= tag_in;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         t5_ff <= t4_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         fr1_ff[a]  <= fr_in[a];
         sq1_ff[a]  <= fr_in[a] * fr_in[a];
         fr2_ff[a]  <= fr1_ff[a];
         smp2_ff[a] <= sq1_ff[a][PB-1:F] * (Three - {1'b0, fr1_ff[a], 1'b0});
         dp3_ff[a]  <= g[a] * off[a];
      end
      wxy3_ff  <= wt[0] * wt[1];
      wz3_ff   <= wt[2];
      w4_ff    <= wprod[F+SB-1:F];
      dsh4_ff  <= dsum[plgn_pkg::DotBits-1:14];
      prod5_ff <= $signed({1'b0, w4_ff}) * dsh4_ff;
   end

   assign tag_out  = t5_ff;
   assign prod_out = prod5_ff;

endmodule

>>> rtl/perlin_gradient_noise_turbulence.sv
// top level: request sequencer, octave accumulation, result register and csr
//
//   channel   ports                         direction   handshake
//   request   req_*                         in          req_valid / req_ready
//   response  rsp_*                         out         rsp_valid / rsp_ready
//   csr       psel penable pwrite paddr ..  in/out      apb, pready tied high
//
// a load item is written to its table when accepted; an evaluate item issues eight corners
// per octave for n octaves (one in raw mode, none if n is zero); one gradient table read per corner.
// the corner datapath is five stages deep and takes a new corner every cycle.
// reset is synchronous; tables are not cleared and must be loaded before use.
// a finished result waits in the output register while the next item is taken;
// the sequencer holds a finished total until that register is free.
module perlin_gradient_noise_turbulence (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_op,
   input  logic [7:0]                           req_table_index,
   input  logic [1:0]                           req_perm_axis,
   input  logic [7:0]                           req_perm_value,
   input  logic signed [15:0]                   req_grad_x,
   input  logic signed [15:0]                   req_grad_y,
   input  logic signed [15:0]                   req_grad_z,
   input  logic signed [31:0]                   req_coord_x,
   input  logic signed [31:0]                   req_coord_y,
   input  logic signed [31:0]                   req_coord_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [20:0]                   rsp_noise_value,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int F   = plgn_pkg::FracBits;
   localparam int IB  = plgn_pkg::IdxBits;
   localparam int OCB = plgn_pkg::OctBits;
   localparam int CB  = plgn_pkg::CntBits;
   localparam int TB  = plgn_pkg::TotBits;
   localparam int RB  = TB - (plgn_pkg::MaxOctaves - 1);
   localparam logic [CB-1:0] MaxOct = CB'(plgn_pkg::MaxOctaves);
   localparam logic signed [RB:0] OutMax = (RB+1)'((1 << (plgn_pkg::OutBits - 1)) - 1);
   localparam logic signed [RB:0] OutMin = -(RB+1)'(1 << (plgn_pkg::OutBits - 1));

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic            mode_ff;
   logic [CB-1:0]   count_ff;
   logic [OCB-1:0]  oct_ff, oct_in, oct_last_ff, oct_last_in;
   logic [2:0]      corner_ff, corner_in;
   logic [31:0]     cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic signed [plgn_pkg::AccBits-1:0] acc_ff, acc_in;
   logic signed [TB-1:0] tot_ff, tot_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [20:0] rsp_value_ff, rsp_value_in;

   logic            accept, csr_write;
   logic [CB-1:0]   n_oct;
   plgn_pkg::tag_type    tag_issue, tag_done;
   plgn_pkg::tbl_wr_type tbl_wr;
   logic [IB-1:0]   perm_x, perm_y, perm_z, grad_addr;
   logic [IB-1:0]   addr_x, addr_y, addr_z;
   logic [3*plgn_pkg::GradBits-1:0] grad_data;
   logic signed [plgn_pkg::ProdBits-1:0] prod;
   logic signed [plgn_pkg::AccBits-1:0]  acc_sum;
   logic signed [plgn_pkg::NoiseBits-1:0] noise;
   logic signed [RB-1:0] r_shift;
   logic signed [RB:0]   r_mag;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == plgn_pkg::REG_OCTAVES) ? {28'd0, count_ff}
                                                          : {31'd0, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         count_ff <= CB'(7);
      end else if (csr_write) begin
         if (paddr[2] == plgn_pkg::REG_MODE) begin
            mode_ff <= pwdata[0];
         end else begin
            count_ff <= pwdata[CB-1:0];
         end
      end
   end

   always_comb begin
      tbl_wr = '0;
      tbl_wr.index      = req_table_index[IB-1:0];
      tbl_wr.perm_value = req_perm_value[IB-1:0];
      tbl_wr.grad       = {req_grad_z, req_grad_y, req_grad_x};
      if (accept && req_op == plgn_pkg::OP_LOAD_GRAD) begin
         tbl_wr.grad_we = 1'b1;
      end
      if (accept && req_op == plgn_pkg::OP_LOAD_PERM) begin
         tbl_wr.perm_we[0] = (req_perm_axis == plgn_pkg::AXIS_X);
         tbl_wr.perm_we[1] = (req_perm_axis == plgn_pkg::AXIS_Y);
         tbl_wr.perm_we[2] = (req_perm_axis == plgn_pkg::AXIS_Z);
      end
   end

   // corner being issued: bit 2 picks the x side, bit 0 the z side
   always_comb begin
      tag_issue           = '0;
      tag_issue.valid     = (state_ff == ST_RUN);
      tag_issue.hi_x      = corner_ff[2];
      tag_issue.hi_y      = corner_ff[1];
      tag_issue.hi_z      = corner_ff[0];
      tag_issue.oct_last  = (corner_ff == 3'd7);
      tag_issue.item_last = (corner_ff == 3'd7) && (oct_ff == oct_last_ff);
      tag_issue.octave    = oct_ff;
      addr_x = cx_ff[F +: IB] + IB'(corner_ff[2]);
      addr_y = cy_ff[F +: IB] + IB'(corner_ff[1]);
      addr_z = cz_ff[F +: IB] + IB'(corner_ff[0]);
   end

   plgn_tables u_tables (
      .clock       (clock),
      .wr          (tbl_wr),
      .perm_addr_x (addr_x),
      .perm_addr_y (addr_y),
      .perm_addr_z (addr_z),
      .perm_x      (perm_x),
      .perm_y      (perm_y),
      .perm_z      (perm_z),
      .grad_addr   (grad_addr),
      .grad_data   (grad_data)
   );

   plgn_corner_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (tag_issue),
      .frac_x    (cx_ff[F-1:0]),
      .frac_y    (cy_ff[F-1:0]),
      .frac_z    (cz_ff[F-1:0]),
      .perm_x    (perm_x),
      .perm_y    (perm_y),
      .perm_z    (perm_z),
      .grad_addr (grad_addr),
      .grad_data (grad_data),
      .tag_out   (tag_done),
      .prod_out  (prod)
   );

   always_comb begin
      n_oct = mode_ff ? ((count_ff > MaxOct) ? MaxOct : count_ff) : CB'(1);
      acc_sum = acc_ff + plgn_pkg::AccBits'(prod);
      noise   = acc_sum[plgn_pkg::AccBits-1:F];
      r_shift = tot_ff[TB-1:plgn_pkg::MaxOctaves-1];
      r_mag   = (mode_ff && r_shift < 0) ? -(RB+1)'(r_shift) : (RB+1)'(r_shift);
      if (r_mag > OutMax) begin
         rsp_value_in = OutMax[20:0];
      end else if (r_mag < OutMin) begin
         rsp_value_in = OutMin[20:0];
      end else begin
         rsp_value_in = r_mag[20:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      oct_in       = oct_ff;
      oct_last_in  = oct_last_ff;
      corner_in    = corner_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      acc_in       = acc_ff;
      tot_in       = tot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (tag_done.valid) begin
         if (tag_done.oct_last) begin
            acc_in = '0;
            tot_in = tot_ff + (TB'(noise) <<< (OCB'(plgn_pkg::MaxOctaves - 1)
                                                - tag_done.octave));
         end else begin
            acc_in = acc_sum;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == plgn_pkg::OP_EVAL) begin
               cx_in       = req_coord_x;
               cy_in       = req_coord_y;
               cz_in       = req_coord_z;
               oct_in      = '0;
               corner_in   = '0;
               acc_in      = '0;
               tot_in      = '0;
               oct_last_in = OCB'(n_oct - CB'(1));
               state_in    = (n_oct == '0) ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            corner_in = corner_ff + 3'd1;
            if (corner_ff == 3'd7) begin
               oct_in = oct_ff + OCB'(1);
               cx_in  = {cx_ff[30:0], 1'b0};
               cy_in  = {cy_ff[30:0], 1'b0};
               cz_in  = {cz_ff[30:0], 1'b0};
               if (oct_ff == oct_last_ff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (tag_done.valid && tag_done.item_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         oct_ff       <= '0;
         corner_ff    <= '0;
         oct_last_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         oct_ff       <= oct_in;
         corner_ff    <= corner_in;
         oct_last_ff  <= oct_last_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      cz_ff  <= cz_in;
      acc_ff <= acc_in;
      tot_ff <= tot_in;
      if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   // corners only come out of the datapath while an item is in flight
   a_tag_in_flight: assert property (@(posedge clock) disable iff (reset)
      tag_done.valid |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("corner result outside an evaluation");

   // a new result is only loaded from the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   // the issue octave never passes the last octave of the item
   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (oct_ff <= oct_last_ff))
      else $error("octave counter ran past its limit");

   // an accepted evaluation leaves idle
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == plgn_pkg::OP_EVAL) |=> (state_ff != ST_IDLE))
      else $error("evaluation accepted but sequencer idle");

endmodule
